[src/rau_pkg.sv]
package rau_pkg;

    localparam int unsigned OpW = 3;
    localparam int unsigned ArgW = 32;
    localparam int unsigned WideW = 64;
    localparam int unsigned DenW = 63;
    localparam int unsigned CntW = 7;

    localparam logic [OpW-1:0] OP_ADD = 3'd0;
    localparam logic [OpW-1:0] OP_SUB = 3'd1;
    localparam logic [OpW-1:0] OP_MUL = 3'd2;
    localparam logic [OpW-1:0] OP_CMP = 3'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic combine;
        logic mod_start;
        logic mod_step;
        logic gcd_swap;
        logic div_start;
        logic div_step;
        logic div_next;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic       err;
        logic       is_cmp;
        logic       y_zero;
        logic       cnt_done;
        logic       div_second;
    } t_status;

endpackage

[src/rau_datapath.sv]
module rau_datapath
    import rau_pkg::*;
(
    input  logic                   i_clk,
    input  logic [OpW-1:0]         i_op,
    input  logic signed [ArgW-1:0] i_a_numerator,
    input  logic signed [ArgW-1:0] i_a_denominator,
    input  logic signed [ArgW-1:0] i_b_numerator,
    input  logic signed [ArgW-1:0] i_b_denominator,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic signed [WideW-1:0] o_result_numerator,
    output logic [DenW-1:0]        o_result_denominator,
    output logic [1:0]             o_status_code,
    output logic [1:0]             o_order
);

    logic [OpW-1:0]          r_op;
    logic signed [ArgW-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [1:0]              r_st;
    logic signed [WideW-1:0] r_p1, r_p2, r_p3;
    logic                    r_neg;
    logic [WideW-1:0]        r_mag, r_den;
    logic [WideW-1:0]        r_x, r_y;
    logic [WideW-1:0]        r_q, r_rem, r_dvd, r_dvs;
    logic [CntW-1:0]         r_cnt;
    logic                    r_second;
    logic [1:0]              r_order;

    logic [1:0]              n_st;
    logic signed [WideW-1:0] n_m1, n_m2;
    logic [WideW:0]          n_trial;

    always_comb begin
        logic two;
        two = (i_op <= OP_CMP);
        if (i_a_denominator == '0) begin
            n_st = ST_ZERO;
        end else if (i_a_denominator < 0) begin
            n_st = ST_NEG;
        end else if (two && i_b_denominator == '0) begin
            n_st = ST_ZERO;
        end else if (two && i_b_denominator < 0) begin
            n_st = ST_NEG;
        end else begin
            n_st = ST_OK;
        end
    end

    always_comb begin
        n_m1 = WideW'(r_an) * WideW'(r_bd);
        n_m2 = WideW'(r_bn) * WideW'(r_ad);
        if (i_cmd.mul2) begin
            n_m1 = WideW'(r_ad) * WideW'(r_bd);
            n_m2 = WideW'(r_an) * WideW'(r_bn);
        end
    end

    assign n_trial = {r_rem[WideW-2:0], r_dvd[WideW-1]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_an <= i_a_numerator;
            r_ad <= i_a_denominator;
            r_bn <= i_b_numerator;
            r_bd <= i_b_denominator;
            r_st <= n_st;
            r_order <= ORD_LESS;
        end
        if (i_cmd.mul1) begin
            r_p1 <= n_m1;
            r_p2 <= n_m2;
        end
        if (i_cmd.mul2) begin
            r_p3 <= (r_op > OP_CMP) ? WideW'(r_ad) : n_m1;
            if (r_op == OP_CMP) begin
                r_order <= (r_p1 < r_p2) ? ORD_LESS :
                           ((r_p1 > r_p2) ? ORD_GREATER : ORD_EQUAL);
            end
            unique case (r_op)
                OP_MUL: begin
                    r_p1 <= n_m2;
                end
                OP_ADD: begin
                    r_p1 <= r_p1 + r_p2;
                end
                OP_SUB: begin
                    r_p1 <= r_p1 - r_p2;
                end
                OP_CMP: begin
                    r_p1 <= r_p1;
                end
                default: begin
                    r_p1 <= WideW'(r_an);
                end
            endcase
        end
        if (i_cmd.combine) begin
            r_neg <= r_p1[WideW-1];
            r_mag <= r_p1[WideW-1] ? WideW'(-r_p1) : WideW'(r_p1);
            r_den <= r_p3;
            r_x   <= r_p1[WideW-1] ? WideW'(-r_p1) : WideW'(r_p1);
            r_y   <= r_p3;
        end
        if (i_cmd.mod_start) begin
            r_dvd <= r_x;
            r_dvs <= r_y;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_start) begin
            r_dvd    <= r_mag;
            r_dvs    <= (r_x == '0) ? WideW'(1) : r_x;
            r_rem    <= '0;
            r_q      <= '0;
            r_cnt    <= '0;
            r_second <= 1'b0;
        end
        if (i_cmd.div_next) begin
            r_mag    <= r_q;
            r_dvd    <= r_den;
            r_rem    <= '0;
            r_q      <= '0;
            r_cnt    <= '0;
            r_second <= 1'b1;
        end
        if (i_cmd.mod_step || i_cmd.div_step) begin
            r_dvd <= {r_dvd[WideW-2:0], 1'b0};
            r_cnt <= r_cnt + CntW'(1);
            if (!n_trial[WideW]) begin
                r_rem <= n_trial[WideW-1:0];
                r_q   <= {r_q[WideW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WideW-2:0], r_dvd[WideW-1]};
                r_q   <= {r_q[WideW-2:0], 1'b0};
            end
        end
        if (i_cmd.gcd_swap) begin
            r_x <= r_y;
            r_y <= r_rem;
        end
        if (i_cmd.finish) begin
            r_den <= r_q;
        end
    end

    assign o_status.err        = (r_st != ST_OK);
    assign o_status.is_cmp     = (r_op == OP_CMP);
    assign o_status.y_zero     = (r_y == '0);
    assign o_status.cnt_done   = (r_cnt == CntW'(WideW - 1));
    assign o_status.div_second = r_second;

    assign o_result_numerator   = (o_status.err || o_status.is_cmp) ? '0 :
                                  (r_neg ? -$signed(r_mag) : $signed(r_mag));
    assign o_result_denominator = (o_status.err || o_status.is_cmp) ? '0 : r_den[DenW-1:0];
    assign o_status_code        = r_st;
    assign o_order              = o_status.err ? ORD_LESS : r_order;

endmodule

[src/rau_control.sv]
module rau_control
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output logic    busy,
    output logic    o_done,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD_TEST, S_MOD, S_SWAP,
        S_DIV_START, S_DIV, S_DIV_NEXT, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_state <= i_status.err ? S_OUT : S_MUL2;
                end
                S_MUL2: begin
                    r_state <= i_status.is_cmp ? S_OUT : S_COMB;
                end
                S_COMB: begin
                    r_state <= S_GCD_TEST;
                end
                S_GCD_TEST: begin
                    r_state <= i_status.y_zero ? S_DIV_START : S_MOD;
                end
                S_MOD: begin
                    if (i_status.cnt_done) begin
                        r_state <= S_SWAP;
                    end
                end
                S_SWAP: begin
                    r_state <= S_GCD_TEST;
                end
                S_DIV_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_status.cnt_done) begin
                        r_state <= i_status.div_second ? S_FIN : S_DIV_NEXT;
                    end
                end
                S_DIV_NEXT: begin
                    r_state <= S_DIV;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && start;
        o_cmd.mul1      = (r_state == S_MUL1);
        o_cmd.mul2      = (r_state == S_MUL2);
        o_cmd.combine   = (r_state == S_COMB);
        o_cmd.mod_start = (r_state == S_GCD_TEST) && !i_status.y_zero;
        o_cmd.mod_step  = (r_state == S_MOD);
        o_cmd.gcd_swap  = (r_state == S_SWAP);
        o_cmd.div_start = (r_state == S_DIV_START);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_next  = (r_state == S_DIV_NEXT);
        o_cmd.finish    = (r_state == S_FIN);
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

[src/rational_arithmetic_unit.sv]
// Rational arithmetic: pulse start while busy is low with the operands; one result appears
// on the o_ ports for exactly one cycle with o_valid high, and must be taken then. Errors end
// once the operands are checked and compares end after the cross products; add, subtract,
// multiply and normalize run Euclid's gcd with a shared restoring divider, one remainder per
// gcd step followed by a test and swap, then two divisions to reduce. A new operation is
// taken only once the previous one is done and busy is low.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OpW-1:0]          i_op,
    input  logic signed [ArgW-1:0]  i_a_numerator,
    input  logic signed [ArgW-1:0]  i_a_denominator,
    input  logic signed [ArgW-1:0]  i_b_numerator,
    input  logic signed [ArgW-1:0]  i_b_denominator,
    output logic                    o_valid,
    output logic signed [WideW-1:0] o_result_numerator,
    output logic [DenW-1:0]         o_result_denominator,
    output logic [1:0]              o_status,
    output logic [1:0]              o_order
);

    t_cmd    cmd;
    t_status stat;

    rau_control u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (stat),
        .busy     (busy),
        .o_done   (o_valid),
        .o_cmd    (cmd)
    );

    rau_datapath u_dp (
        .i_clk                (i_clk),
        .i_op                 (i_op),
        .i_a_numerator        (i_a_numerator),
        .i_a_denominator      (i_a_denominator),
        .i_b_numerator        (i_b_numerator),
        .i_b_denominator      (i_b_denominator),
        .i_cmd                (cmd),
        .o_status             (stat),
        .o_result_numerator   (o_result_numerator),
        .o_result_denominator (o_result_denominator),
        .o_status_code        (o_status),
        .o_order              (o_order)
    );

`ifndef ASSERT_OFF
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy during result");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result_denominator == '0))
        else $error("error result not cleared");
`endif

endmodule
